FILE: design/trpf_pkg.sv
// trpf_pkg: shared types and constants of the timed RGB phase fader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package trpf_pkg;

  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DUR_FIELD_W = 16;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_PHASE_LAST = 3'd5;
  localparam logic [2:0] CFG_PHASE_COUNT = 3'd6;
  localparam logic [2:0] MAX_PHASE_IDX = 3'd5;
  localparam logic [2:0] MAX_PHASE_CNT = 3'd6;

  // One phase register, MSB first: duration, start RGB, end RGB
  typedef struct packed {
    logic [DUR_FIELD_W-1:0] dur;
    logic [7:0]             s_r;
    logic [7:0]             s_g;
    logic [7:0]             s_b;
    logic [7:0]             e_r;
    logic [7:0]             e_g;
    logic [7:0]             e_b;
  } phase_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                   in_cycle;
    logic [2:0]             idx;
    logic [DUR_FIELD_W-1:0] dur;
    logic [DUR_FIELD_W-1:0] t;
    logic [7:0]             s_r;
    logic [7:0]             s_g;
    logic [7:0]             s_b;
    logic [7:0]             e_r;
    logic [7:0]             e_g;
    logic [7:0]             e_b;
  } item_t;

  typedef struct packed {
    logic       in_cycle;
    logic [2:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

endpackage

FILE: design/trpf_front.sv
// trpf_front: input register, elapsed time and phase lookup.
// Depends on trpf_pkg; feeds trpf_queue.
`timescale 1ns / 1ps

module trpf_front #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned DW = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [TIME_BITS-1:0]              start_time_i,
  input  logic [TIME_BITS-1:0]              current_time_i,
  input  trpf_pkg::phase_t [trpf_pkg::NUM_PHASES-1:0] phase_i,
  input  logic [2:0]                        phase_count_i,
  output logic                              push_o,
  output trpf_pkg::item_t                   item_o,
  input  logic                              full_i
);
  import trpf_pkg::*;

  localparam int unsigned CW = DW + 3;
  localparam int unsigned XW = (TIME_BITS > CW) ? TIME_BITS : CW;

  logic                 vld_q;
  logic [TIME_BITS-1:0] elapsed_q;
  logic                 accept;

  logic [NUM_PHASES-1:0][DW-1:0] dur;
  logic [NUM_PHASES-1:0][CW-1:0] lo;
  logic [NUM_PHASES-1:0][CW-1:0] hi;
  logic [NUM_PHASES-1:0]         hit;
  logic [2:0]                    cnt;

  assign push_o     = vld_q && !full_i;
  assign in_ready_o = !vld_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  // modular difference, wraps cleanly
  always_ff @(posedge clk_i) begin
    if (accept) begin
      elapsed_q <= current_time_i - start_time_i;
    end
  end

  // cumulative phase bounds
  always_comb begin
    logic [CW-1:0] acc;
    acc = '0;
    cnt = (phase_count_i > MAX_PHASE_CNT) ? MAX_PHASE_CNT : phase_count_i;
    for (int i = 0; i < NUM_PHASES; i++) begin
      dur[i] = phase_i[i].dur[DW-1:0];
      lo[i]  = acc;
      hi[i]  = acc + CW'(dur[i]);
      acc    = hi[i];
      hit[i] = (3'(i) < cnt) && (dur[i] != '0) &&
               (XW'(elapsed_q) >= XW'(lo[i])) && (XW'(elapsed_q) < XW'(hi[i]));
    end
  end

  always_comb begin
    item_o = '0;
    for (int i = NUM_PHASES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        item_o.in_cycle = 1'b1;
        item_o.idx      = 3'(i);
        item_o.dur      = DUR_FIELD_W'(dur[i]);
        item_o.t        = DUR_FIELD_W'(elapsed_q[DW-1:0] - lo[i][DW-1:0]);
        item_o.s_r      = phase_i[i].s_r;
        item_o.s_g      = phase_i[i].s_g;
        item_o.s_b      = phase_i[i].s_b;
        item_o.e_r      = phase_i[i].e_r;
        item_o.e_g      = phase_i[i].e_g;
        item_o.e_b      = phase_i[i].e_b;
      end
    end
  end

endmodule

FILE: design/trpf_queue.sv
// trpf_queue: small FIFO of classified items between front and back.
// Depends on trpf_pkg.
`timescale 1ns / 1ps

module trpf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  trpf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output trpf_pkg::item_t item_o,
  output logic            empty_o
);
  import trpf_pkg::*;

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QAW:0]   count_q;
  logic [QAW:0]   count_d;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: design/trpf_back.sv
// trpf_back: product stage, numerator stage and an 8-step restoring
// divider per color channel. Depends on trpf_pkg; pops trpf_queue.
`timescale 1ns / 1ps

module trpf_back #(
  parameter int unsigned DW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trpf_pkg::item_t   item_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trpf_pkg::result_t result_o
);
  import trpf_pkg::*;

  localparam int unsigned RW = DW + 8;
  localparam int unsigned NSTEP = 8;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [7:0]    q;
  } lane_t;

  typedef struct packed {
    logic             in_cycle;
    logic [2:0]       idx;
    logic [DW-1:0]    dur;
    lane_t [2:0]      ln;
  } dstage_t;

  typedef struct packed {
    logic                 in_cycle;
    logic [2:0]           idx;
    logic [DW-1:0]        dur;
    logic [2:0][RW-1:0]   p1;
    logic [2:0][RW-1:0]   p2;
    logic [2:0]           neg;
  } mstage_t;

  logic                 en;
  logic                 m_vld_q;
  mstage_t              m_q;
  mstage_t              m_d;
  logic [NSTEP:0]       d_vld_q;
  dstage_t [NSTEP:0]    d_q;
  dstage_t              num_d;

  function automatic dstage_t div_step(dstage_t x, int unsigned k);
    dstage_t       y;
    logic [RW-1:0] sh;
    logic          ge;
    y = x;
    sh = RW'(x.dur) << k;
    for (int c = 0; c < 3; c++) begin
      ge = (x.ln[c].rem >= sh);
      y.ln[c].rem = ge ? (x.ln[c].rem - sh) : x.ln[c].rem;
      y.ln[c].q   = {x.ln[c].q[6:0], ge};
    end
    return y;
  endfunction

  // whole back pipe moves together; the last stage is the output register
  assign en          = !d_vld_q[NSTEP] || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = d_vld_q[NSTEP];

  always_comb begin
    logic [2:0][7:0] s;
    logic [2:0][7:0] e;
    logic [7:0]      diff;
    s = {item_i.s_b, item_i.s_g, item_i.s_r};
    e = {item_i.e_b, item_i.e_g, item_i.e_r};
    m_d.in_cycle = item_i.in_cycle;
    m_d.idx      = item_i.idx;
    m_d.dur      = item_i.dur[DW-1:0];
    for (int c = 0; c < 3; c++) begin
      m_d.neg[c] = (e[c] < s[c]);
      diff       = m_d.neg[c] ? (s[c] - e[c]) : (e[c] - s[c]);
      m_d.p1[c]  = RW'(s[c]) * RW'(item_i.dur[DW-1:0]);
      m_d.p2[c]  = RW'(item_i.t[DW-1:0]) * RW'(diff);
    end
  end

  // numerator start*dur +/- t*|end-start|, always within 0..255*dur
  always_comb begin
    num_d.in_cycle = m_q.in_cycle;
    num_d.idx      = m_q.idx;
    num_d.dur      = m_q.dur;
    for (int c = 0; c < 3; c++) begin
      num_d.ln[c].rem = m_q.neg[c] ? (m_q.p1[c] - m_q.p2[c]) : (m_q.p1[c] + m_q.p2[c]);
      num_d.ln[c].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      d_vld_q <= '0;
    end else if (en) begin
      m_vld_q <= pop_o;
      d_vld_q <= {d_vld_q[NSTEP-1:0], m_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      d_q[0] <= num_d;
      for (int j = 1; j <= NSTEP; j++) begin
        d_q[j] <= div_step(d_q[j-1], NSTEP - j);
      end
    end
  end

  always_comb begin
    result_o.in_cycle = d_q[NSTEP].in_cycle;
    result_o.idx      = d_q[NSTEP].in_cycle ? d_q[NSTEP].idx : 3'd0;
    result_o.red      = d_q[NSTEP].in_cycle ? d_q[NSTEP].ln[0].q : 8'd0;
    result_o.green    = d_q[NSTEP].in_cycle ? d_q[NSTEP].ln[1].q : 8'd0;
    result_o.blue     = d_q[NSTEP].in_cycle ? d_q[NSTEP].ln[2].q : 8'd0;
  end

`ifndef SYNTHESIS
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> en) else $error("back pops while stalled");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_o)))
    else $error("result changed while stalled");
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_o.in_cycle) |->
    (result_o.red == 8'd0 && result_o.green == 8'd0 && result_o.blue == 8'd0))
    else $error("colors not cleared outside cycle");
`endif

endmodule

FILE: design/timed_rgb_phase_fader.sv
// timed_rgb_phase_fader: top level, configuration registers and the
// front / queue / back pipeline. Depends on trpf_pkg and all trpf_* modules.
`timescale 1ns / 1ps

// Channel    | Dir | Transfer when                 | Payload
// cfg        | in  | cfg_we_i                      | cfg_idx_i, cfg_wdata_i
// s_axis     | in  | s_axis_tvalid_i & tready_o    | start_time, current_time
// m_axis     | out | m_axis_tvalid_o & tready_i    | in_cycle; phase_index, RGB
//
// One item per cycle sustained while results are taken. Path from input
// transfer to result: input register, queue write, product stage, numerator
// stage, 8 divider steps. The divider sets the latency, not the rate.
// Reset clears the phase registers, phase_count and all valid state.
// The front stalls only when the 4-entry queue is full; the back stalls as
// a whole while its output register holds an untaken result.

module timed_rgb_phase_fader #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration writes
  input  logic                                     cfg_we_i,
  input  logic [2:0]                               cfg_idx_i,
  input  logic [63:0]                              cfg_wdata_i,
  // query stream
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: start_time, current_time (TIME_BITS each), zero pad to bytes
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]         s_axis_tdata_i,
  // result stream
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // tdata: phase_index[2:0], red[10:3], green[18:11], blue[26:19], zero pad
  output logic [trpf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  // tuser: in_cycle
  output logic                                     m_axis_tuser_o
);
  import trpf_pkg::*;

  // durations keep at most the 16 bits of the register field
  localparam int unsigned DW = (DURATION_BITS < DUR_FIELD_W) ? DURATION_BITS : DUR_FIELD_W;

  phase_t [NUM_PHASES-1:0] phase_q;
  logic [2:0]              phase_count_q;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  item_t   q_in;
  item_t   q_out;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      phase_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= CFG_PHASE_LAST) begin
        phase_q[cfg_idx_i] <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_PHASE_COUNT) begin
        phase_count_q <= cfg_wdata_i[2:0];
      end
    end
  end

  trpf_front #(
    .TIME_BITS (TIME_BITS),
    .DW        (DW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .start_time_i   (s_axis_tdata_i[TIME_BITS-1:0]),
    .current_time_i (s_axis_tdata_i[2*TIME_BITS-1:TIME_BITS]),
    .phase_i        (phase_q),
    .phase_count_i  (phase_count_q),
    .push_o         (q_push),
    .item_o         (q_in),
    .full_i         (q_full)
  );

  trpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  trpf_back #(
    .DW (DW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (res)
  );

  assign m_axis_tuser_o = res.in_cycle;
  assign m_axis_tdata_o = {5'd0, res.blue, res.green, res.red, res.idx};

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= MAX_PHASE_IDX))
    else $error("phase index out of range");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("result not cleared outside cycle");
  a_miss_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && phase_count_q == 3'd0) |-> !q_in.in_cycle)
    else $error("phase found with no phases in use");
`endif

endmodule
